[rtl/wfp_pkg.sv]
// ----------------------------------------------------------------------------
// wfp_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte step for the
// waveform frame packetizer.
// ----------------------------------------------------------------------------
package wfp_pkg;

  // Input stream layout: tdata fields from bit 0 up
  localparam int unsigned WFP_IN_TDATA_W  = 192;
  localparam int unsigned WFP_OFS_VALID   = 0;
  localparam int unsigned WFP_OFS_NEAR    = 1;
  localparam int unsigned WFP_OFS_STATE   = 2;
  localparam int unsigned WFP_OFS_SEQ     = 10;
  localparam int unsigned WFP_OFS_CAPTURE = 42;
  localparam int unsigned WFP_OFS_CURRENT = 74;
  localparam int unsigned WFP_OFS_MEAN    = 106;
  localparam int unsigned WFP_OFS_MV      = 122;
  localparam int unsigned WFP_OFS_COUNT   = 138;
  localparam int unsigned WFP_OFS_MIN     = 154;
  localparam int unsigned WFP_OFS_MAX     = 170;

  localparam int unsigned WFP_OUT_TDATA_W = 8;
  localparam int unsigned WFP_CFG_ADDR_W  = 2;
  localparam int unsigned WFP_CFG_DATA_W  = 32;
  localparam int unsigned WFP_COL_W       = 14;

  localparam int unsigned WFP_QUEUE_DEPTH = 2;

  typedef enum logic {
    WFP_OP_HEADER = 1'b0,
    WFP_OP_COLUMN = 1'b1
  } wfp_op_e;

  typedef enum logic [WFP_CFG_ADDR_W-1:0] {
    WFP_REG_STALE_LIMIT = 2'd0,
    WFP_REG_COL_PERIOD  = 2'd1,
    WFP_REG_COL_LIMIT   = 2'd2,
    WFP_REG_PLOT_MAX    = 2'd3
  } wfp_reg_e;

  localparam logic [31:0] WFP_RST_STALE_LIMIT = 32'd1000;
  localparam logic [15:0] WFP_RST_COL_PERIOD  = 16'd10;
  localparam logic [13:0] WFP_RST_COL_LIMIT   = 14'd128;
  localparam logic [15:0] WFP_RST_PLOT_MAX    = 16'd3300;

  localparam logic [15:0] WFP_CRC_POLY = 16'h1021;
  localparam logic [15:0] WFP_CRC_INIT = 16'hFFFF;

  localparam logic [7:0]  WFP_MAGIC_A  = 8'h41;
  localparam logic [7:0]  WFP_MAGIC_D  = 8'h44;
  localparam logic [7:0]  WFP_MAGIC_C  = 8'h43;
  localparam logic [7:0]  WFP_MAGIC_W  = 8'h57;
  localparam logic [7:0]  WFP_VERSION  = 8'h01;
  localparam logic [15:0] WFP_META_BYTES = 16'd24;

  localparam int unsigned WFP_HDR_BYTES = 30;
  localparam int unsigned WFP_IDX_W     = 5;
  localparam logic [WFP_IDX_W-1:0] WFP_HDR_LAST   = 5'd29;
  localparam logic [WFP_IDX_W-1:0] WFP_COL_LAST   = 5'd3;
  localparam logic [WFP_IDX_W-1:0] WFP_MAGIC_LAST = 5'd3;

  typedef enum logic [1:0] {
    WFP_BK_DATA   = 2'd0,
    WFP_BK_CRC_LO = 2'd1,
    WFP_BK_CRC_HI = 2'd2
  } wfp_bk_state_e;

  typedef struct packed {
    logic [31:0] stale_limit;
    logic [15:0] col_period;
    logic [13:0] col_limit;
    logic [15:0] plot_max;
  } wfp_cfg_t;

  // One queued job: a header or a column pair; fin closes the packet with CRC
  typedef struct packed {
    logic        is_col;
    logic        fin;
    logic [2:0]  flags;
    logic [7:0]  run_state;
    logic [31:0] seq;
    logic [31:0] ts;
    logic [15:0] w0;   // mean or column min
    logic [15:0] w1;   // millivolts or column max
    logic [13:0] cnt;
  } wfp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wfp_q_status_t;

  function automatic logic [15:0] wfp_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ WFP_CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/wfp_front.sv]
// ----------------------------------------------------------------------------
// wfp_front
// Accepts input transactions, tracks the open frame and queues header and
// column jobs; rejected headers and stray columns are dropped here.
// ----------------------------------------------------------------------------
module wfp_front
  import wfp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wfp_cfg_t                  cfg_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [WFP_IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]                s_axis_tuser,
  input  wfp_q_status_t             q_status_i,
  output logic                      push_o,
  output wfp_entry_t                entry_o
);

  logic [WFP_COL_W-1:0] left_q, left_d;
  logic                 accept, is_hdr, too_many, stale;
  logic [15:0]          count;
  logic [31:0]          capture, current, age;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_hdr        = (wfp_op_e'(s_axis_tuser[0]) == WFP_OP_HEADER);
  assign count         = s_axis_tdata[WFP_OFS_COUNT +: 16];
  assign capture       = s_axis_tdata[WFP_OFS_CAPTURE +: 32];
  assign current       = s_axis_tdata[WFP_OFS_CURRENT +: 32];
  assign age           = current - capture;
  assign stale         = age > cfg_i.stale_limit;
  assign too_many      = count > {2'b00, cfg_i.col_limit};

  always_comb begin
    push_o = 1'b0;
    left_d = left_q;
    if (accept) begin
      if (is_hdr) begin
        if (!too_many) begin
          push_o = 1'b1;
          left_d = count[WFP_COL_W-1:0];
        end
      end else if (left_q != '0) begin
        push_o = 1'b1;
        left_d = left_q - 1'b1;
      end
    end
  end

  always_comb begin
    entry_o.is_col    = !is_hdr;
    entry_o.fin       = is_hdr ? (count == 16'd0) : (left_q == WFP_COL_W'(1));
    entry_o.flags     = {stale, s_axis_tdata[WFP_OFS_NEAR], s_axis_tdata[WFP_OFS_VALID]};
    entry_o.run_state = s_axis_tdata[WFP_OFS_STATE +: 8];
    entry_o.seq       = s_axis_tdata[WFP_OFS_SEQ +: 32];
    entry_o.ts        = capture;
    entry_o.w0        = is_hdr ? s_axis_tdata[WFP_OFS_MEAN +: 16] : s_axis_tdata[WFP_OFS_MIN +: 16];
    entry_o.w1        = is_hdr ? s_axis_tdata[WFP_OFS_MV +: 16] : s_axis_tdata[WFP_OFS_MAX +: 16];
    entry_o.cnt       = count[WFP_COL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

endmodule

[rtl/wfp_queue.sv]
// ----------------------------------------------------------------------------
// wfp_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module wfp_queue
  import wfp_pkg::*;
#(
  parameter int unsigned Depth = WFP_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wfp_entry_t    entry_i,
  input  logic          pop_i,
  output wfp_entry_t    head_o,
  output wfp_q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wfp_entry_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/wfp_back.sv]
// ----------------------------------------------------------------------------
// wfp_back
// Serializes queued jobs into packet bytes, runs the CRC and closes packets.
// ----------------------------------------------------------------------------
module wfp_back
  import wfp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wfp_cfg_t                   cfg_i,
  input  wfp_entry_t                 head_i,
  input  wfp_q_status_t              q_status_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [WFP_OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                       m_axis_tlast
);

  wfp_bk_state_e            state_q, state_d;
  logic [WFP_IDX_W-1:0]     idx_q;
  logic [15:0]              crc_q;
  logic                     out_valid_q, out_last_q;
  logic [7:0]               out_data_q;

  logic                     load, last_data, covered, byte_last;
  logic [7:0]               byte_sel;
  logic [15:0]              pkt_len;
  logic [WFP_HDR_BYTES*8-1:0] hdr_vec;
  logic [31:0]              col_vec;

  assign load      = !q_status_i.empty && (!out_valid_q || m_axis_tready);
  assign last_data = head_i.is_col ? (idx_q == WFP_COL_LAST) : (idx_q == WFP_HDR_LAST);
  assign covered   = head_i.is_col || (idx_q > WFP_MAGIC_LAST);
  assign pkt_len   = WFP_META_BYTES + {head_i.cnt, 2'b00};
  assign hdr_vec   = {cfg_i.plot_max, 2'b00, cfg_i.col_limit, cfg_i.col_period,
                      2'b00, head_i.cnt, head_i.w1, head_i.w0, head_i.ts, head_i.seq,
                      8'h00, head_i.run_state, 5'b00000, head_i.flags, WFP_VERSION,
                      pkt_len, WFP_MAGIC_W, WFP_MAGIC_C, WFP_MAGIC_D, WFP_MAGIC_A};
  assign col_vec   = {head_i.w1, head_i.w0};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      WFP_BK_DATA: begin
        if (load && last_data && head_i.fin) begin
          state_d = WFP_BK_CRC_LO;
        end
      end
      WFP_BK_CRC_LO: begin
        if (load) begin
          state_d = WFP_BK_CRC_HI;
        end
      end
      WFP_BK_CRC_HI: begin
        if (load) begin
          state_d = WFP_BK_DATA;
        end
      end
      default: state_d = WFP_BK_DATA;
    endcase
  end

  always_comb begin
    byte_sel  = 8'h00;
    byte_last = 1'b0;
    pop_o     = 1'b0;
    unique case (state_q)
      WFP_BK_DATA: begin
        byte_sel = head_i.is_col ? col_vec[{idx_q[1:0], 3'b000} +: 8]
                                 : hdr_vec[{idx_q, 3'b000} +: 8];
        pop_o    = load && last_data && !head_i.fin;
      end
      WFP_BK_CRC_LO: begin
        byte_sel = crc_q[7:0];
      end
      WFP_BK_CRC_HI: begin
        byte_sel  = crc_q[15:8];
        byte_last = 1'b1;
        pop_o     = load;
      end
      default: begin
        byte_sel = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WFP_BK_DATA;
      idx_q       <= '0;
      crc_q       <= WFP_CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
        if (state_q == WFP_BK_DATA) begin
          idx_q <= last_data ? '0 : idx_q + 1'b1;
          if (!head_i.is_col && idx_q == '0) begin
            crc_q <= WFP_CRC_INIT;
          end else if (covered) begin
            crc_q <= wfp_crc_byte(crc_q, byte_sel);
          end
        end else if (state_q == WFP_BK_CRC_HI) begin
          crc_q <= WFP_CRC_INIT;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= byte_sel;
      out_last_q <= byte_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[rtl/wave_frame_packetizer.sv]
// Path: input -> job queue -> output byte register. Throughput: one byte per
// cycle from the byte serializer while the sink is ready; a column is 4 bytes
// (6 when it closes the packet), a header 30 (32 with no columns). Dropped
// transactions queue no job. A job queue decouples input and output.
// Reset: config registers take their defaults, the queue empties, no frame open.
// ----------------------------------------------------------------------------
// wave_frame_packetizer
// Waveform packet builder with CRC-16/CCITT-FALSE trailer; top level holding
// the configuration registers.
// ----------------------------------------------------------------------------
module wave_frame_packetizer
  import wfp_pkg::*;
#(
  parameter int unsigned QueueDepth = WFP_QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [WFP_CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [WFP_CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // valid_flag, near_limit, run_state, sequence_number, capture_time_ms,
  // current_time_ms, raw_mean, millivolts, column_count, column_min,
  // column_max, zero pad
  input  logic [WFP_IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]                 s_axis_tuser,   // operation
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [WFP_OUT_TDATA_W-1:0] m_axis_tdata,   // out_byte
  output logic                       m_axis_tlast
);

  wfp_cfg_t      cfg_q;
  wfp_entry_t    push_entry, head;
  wfp_q_status_t q_status;
  logic          push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_limit <= WFP_RST_STALE_LIMIT;
      cfg_q.col_period  <= WFP_RST_COL_PERIOD;
      cfg_q.col_limit   <= WFP_RST_COL_LIMIT;
      cfg_q.plot_max    <= WFP_RST_PLOT_MAX;
    end else if (cfg_we_i) begin
      unique case (wfp_reg_e'(cfg_addr_i))
        WFP_REG_STALE_LIMIT: cfg_q.stale_limit <= cfg_data_i;
        WFP_REG_COL_PERIOD:  cfg_q.col_period  <= cfg_data_i[15:0];
        WFP_REG_COL_LIMIT:   cfg_q.col_limit   <= cfg_data_i[WFP_COL_W-1:0];
        WFP_REG_PLOT_MAX:    cfg_q.plot_max    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  wfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  wfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  wfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTH
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full) else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty) else $error("queue pop while empty");

  a_status_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty)) else $error("queue both full and empty");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid) else $error("job retired without a byte issued");
`endif

endmodule

[test/wfp_tb_pkg.sv]
// ----------------------------------------------------------------------------
// wfp_tb_pkg
// Transaction type and packet scoreboard for the waveform frame packetizer
// bench: predicts the byte stream of each accepted input transaction and
// checks output bytes in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package wfp_tb_pkg;
  import wfp_pkg::*;

  localparam logic [15:0] CCITT_POLY    = 16'h1021;
  localparam logic [15:0] CCITT_SEED    = 16'hFFFF;
  localparam logic [31:0] PKT_MAGIC     = "ADCW";
  localparam logic [7:0]  PKT_VERSION   = 8'h01;
  localparam logic [15:0] PKT_FIXED_LEN = 16'd24;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct {
    wfp_op_e     op;
    logic        valid_flag;
    logic        near_limit;
    logic [7:0]  run_state;
    logic [31:0] seq;
    logic [31:0] capture;
    logic [31:0] current;
    logic [15:0] mean;
    logic [15:0] mv;
    logic [15:0] count;
    logic [15:0] col_min;
    logic [15:0] col_max;
  } wfp_item_t;

  class wfp_packet_scoreboard;
    logic [31:0] stale_limit;
    logic [15:0] col_period;
    logic [13:0] col_limit;
    logic [15:0] plot_max;
    logic [15:0] crc;
    logic [13:0] cols_left;
    bit          in_frame;
    logic [8:0]  expected_bytes[$];  // {last, byte}
    int unsigned mismatches;

    function new();
      stale_limit = 32'd1000;
      col_period  = 16'd10;
      col_limit   = 14'd128;
      plot_max    = 16'd3300;
      crc         = CCITT_SEED;
      cols_left   = '0;
      in_frame    = 1'b0;
      mismatches  = 0;
    endfunction

    function void write_reg(wfp_reg_e idx, logic [31:0] val);
      case (idx)
        WFP_REG_STALE_LIMIT: stale_limit = val;
        WFP_REG_COL_PERIOD:  col_period = val[15:0];
        WFP_REG_COL_LIMIT:   col_limit = val[13:0];
        WFP_REG_PLOT_MAX:    plot_max = val[15:0];
        default: ;
      endcase
    endfunction

    // MSB-first CRC update, one bit at a time
    function logic [15:0] crc_after(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int k = 7; k >= 0; k--) begin
        fb = r[15] ^ b[k];
        r = {r[14:0], 1'b0};
        if (fb) r = r ^ CCITT_POLY;
      end
      return r;
    endfunction

    function void emit(logic [7:0] b, bit in_crc);
      if (in_crc) crc = crc_after(crc, b);
      expected_bytes.push_back({1'b0, b});
    endfunction

    function void emit16(logic [15:0] v);
      emit(v[7:0], 1'b1);
      emit(v[15:8], 1'b1);
    endfunction

    function void emit32(logic [31:0] v);
      emit16(v[15:0]);
      emit16(v[31:16]);
    endfunction

    function void close_packet();
      logic [15:0] c;
      c = crc;
      emit(c[7:0], 1'b0);
      expected_bytes.push_back({1'b1, c[15:8]});
      in_frame  = 1'b0;
      cols_left = '0;
      crc       = CCITT_SEED;
    endfunction

    function void note_item(wfp_item_t it);
      logic [31:0] age;
      logic [7:0]  flags;
      if (it.op == WFP_OP_HEADER) begin
        if (it.count > {2'b00, col_limit}) return;
        crc = CCITT_SEED;
        for (int i = 3; i >= 0; i--) emit(PKT_MAGIC[i*8 +: 8], 1'b0);
        emit16(PKT_FIXED_LEN + {it.count[13:0], 2'b00});
        emit(PKT_VERSION, 1'b1);
        age = it.current - it.capture;
        flags = {5'b0, age > stale_limit, it.near_limit, it.valid_flag};
        emit(flags, 1'b1);
        emit(it.run_state, 1'b1);
        emit(8'h00, 1'b1);
        emit32(it.seq);
        emit32(it.capture);
        emit16(it.mean);
        emit16(it.mv);
        emit16(it.count);
        emit16(col_period);
        emit16({2'b00, col_limit});
        emit16(plot_max);
        in_frame  = 1'b1;
        cols_left = it.count[13:0];
        if (cols_left == '0) close_packet();
      end else if (in_frame && cols_left != '0) begin
        emit16(it.col_min);
        emit16(it.col_max);
        cols_left--;
        if (cols_left == '0) close_packet();
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      logic [8:0] want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected output byte: data %02h last %0b", data, last);
        return;
      end
      want = expected_bytes.pop_front();
      if (want[7:0] !== data || want[8] !== last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("output byte mismatch: expected data %02h last %0b, got data %02h last %0b",
                   want[7:0], want[8], data, last);
      end
    endfunction

    function int unsigned pending();
      return unsigned'(expected_bytes.size());
    endfunction
  endclass

endpackage

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream-level bench for the waveform frame packetizer: directed packets,
// then random framed traffic under several register settings, with random
// source bursts, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import wfp_pkg::*;
  import wfp_tb_pkg::*;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [WFP_CFG_ADDR_W-1:0]  cfg_addr_i = WFP_REG_STALE_LIMIT;
  logic [WFP_CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [WFP_IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                 s_axis_tuser = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [WFP_OUT_TDATA_W-1:0] m_axis_tdata;
  logic                       m_axis_tlast;

  wfp_packet_scoreboard sb;
  int unsigned burst_left = 0;
  bit          tvalid_lowered = 1'b1;
  bit          hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  wave_frame_packetizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin : watchdog
    #2_000_000;
    $display("wave_frame_packetizer verification failed");
    $finish;
  end

  function automatic logic [WFP_IN_TDATA_W-1:0] pack_item(wfp_item_t it);
    logic [WFP_IN_TDATA_W-1:0] d;
    d = '0;
    d[WFP_OFS_VALID]        = it.valid_flag;
    d[WFP_OFS_NEAR]         = it.near_limit;
    d[WFP_OFS_STATE +: 8]   = it.run_state;
    d[WFP_OFS_SEQ +: 32]    = it.seq;
    d[WFP_OFS_CAPTURE +: 32] = it.capture;
    d[WFP_OFS_CURRENT +: 32] = it.current;
    d[WFP_OFS_MEAN +: 16]   = it.mean;
    d[WFP_OFS_MV +: 16]     = it.mv;
    d[WFP_OFS_COUNT +: 16]  = it.count;
    d[WFP_OFS_MIN +: 16]    = it.col_min;
    d[WFP_OFS_MAX +: 16]    = it.col_max;
    return d;
  endfunction

  // ages land on the stale boundary two times in four
  function automatic wfp_item_t random_item(wfp_op_e op, logic [15:0] count);
    wfp_item_t it;
    it.op         = op;
    it.valid_flag = 1'($urandom);
    it.near_limit = 1'($urandom);
    it.run_state  = 8'($urandom);
    it.seq        = $urandom;
    it.capture    = $urandom;
    case ($urandom_range(0, 3))
      0:       it.current = it.capture + sb.stale_limit;
      1:       it.current = it.capture + sb.stale_limit + 32'd1;
      default: it.current = $urandom;
    endcase
    it.mean    = 16'($urandom);
    it.mv      = 16'($urandom);
    it.count   = count;
    it.col_min = 16'($urandom);
    it.col_max = 16'($urandom);
    return it;
  endfunction

  function automatic wfp_item_t column_item(logic [15:0] lo, logic [15:0] hi);
    wfp_item_t it;
    it = random_item(WFP_OP_COLUMN, 16'($urandom));
    it.col_min = lo;
    it.col_max = hi;
    return it;
  endfunction

  task automatic send_item(wfp_item_t it);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_item(it);
    s_axis_tuser  <= it.op;
    tvalid_lowered = 1'b0;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        tvalid_lowered = 1'b1;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_header(logic [15:0] count);
    send_item(random_item(WFP_OP_HEADER, count));
  endtask

  task automatic send_column();
    send_item(column_item(16'($urandom), 16'($urandom)));
  endtask

  // drain all pending bytes plus margin for jobs that produce nothing
  task automatic settle();
    if (!tvalid_lowered) begin
      s_axis_tvalid <= 1'b0;
      tvalid_lowered = 1'b1;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(wfp_reg_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // narrow registers get random upper bits, which must be dropped
  task automatic configure(logic [31:0] stale, logic [15:0] period, logic [13:0] limit,
                           logic [15:0] plot);
    write_reg(WFP_REG_STALE_LIMIT, stale);
    write_reg(WFP_REG_COL_PERIOD, {16'($urandom), period});
    write_reg(WFP_REG_COL_LIMIT, {18'($urandom), limit});
    write_reg(WFP_REG_PLOT_MAX, {16'($urandom), plot});
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed();
    wfp_item_t it;
    send_column();
    it = random_item(WFP_OP_HEADER, 16'd0);
    it.valid_flag = 1'b1;
    it.near_limit = 1'b1;
    it.run_state  = 8'hFF;
    it.seq        = 32'hFFFF_FFFF;
    it.capture    = 32'h0;
    it.current    = 32'hFFFF_FFFF;
    it.mean       = 16'hFFFF;
    it.mv         = 16'hFFFF;
    send_item(it);
    it.valid_flag = 1'b0;
    it.near_limit = 1'b0;
    it.run_state  = 8'h00;
    it.seq        = 32'h0;
    it.capture    = 32'hFFFF_FFF0;
    it.current    = 32'hFFFF_FFF0 + 32'd1000;
    it.mean       = 16'h0;
    it.mv         = 16'h0;
    send_item(it);
    it.current    = it.current + 32'd1;
    send_item(it);
    send_header(16'd2);
    send_item(column_item(16'h0000, 16'hFFFF));
    send_item(column_item(16'hFFFF, 16'h0000));
    send_column();
    send_header(16'd129);
    // oversized header inside an open frame leaves the frame running
    send_header(16'd3);
    send_column();
    send_header(16'hFFFF);
    send_column();
    send_column();
    // new header abandons an open frame
    send_header(16'd5);
    send_column();
    send_header(16'd1);
    send_column();
    send_header(16'd128);
    send_column();
    send_header(16'd0);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned sent;
    int unsigned lim;
    int unsigned cnt;
    int unsigned cols;
    int unsigned r;
    sent = 0;
    while (sent < n) begin
      lim = 32'(sb.col_limit);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_column();
      end else if (r < 12) begin
        cnt = $urandom_range(lim + 1, 65535);
        send_header(16'(cnt));
        sent++;
      end else begin
        if (lim > 64 && $urandom_range(0, 9) == 0)
          cnt = ($urandom_range(0, 1) == 1) ? lim : $urandom_range(0, lim);
        else if (lim <= 40 && $urandom_range(0, 7) == 0)
          cnt = lim;
        else
          cnt = $urandom_range(0, (lim < 6) ? lim : 6);
        cols = cnt;
        if (cols > 40 || $urandom_range(0, 9) == 0)
          cols = $urandom_range(0, (cnt < 4) ? cnt : 4);
        send_header(16'(cnt));
        sent++;
        repeat (cols) begin
          send_column();
          sent++;
        end
      end
    end
  endtask

  initial begin : sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 50;
    hold_left = 0;
    tick      = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    settle();
    configure(32'd0, 16'd0, 14'd0, 16'd0);
    random_traffic(30);
    settle();
    configure(32'hFFFF_FFFF, 16'hFFFF, 14'd16377, 16'hFFFF);
    random_traffic(40);
    settle();
    configure($urandom, 16'($urandom), 14'($urandom_range(1, 8)), 16'($urandom));
    hold_req = 1'b1;
    random_traffic(60);
    settle();
    configure($urandom, 16'($urandom), 14'($urandom_range(9, 40)), 16'($urandom));
    random_traffic(60);
    settle();
    configure($urandom_range(0, 2000), 16'($urandom), 14'd128, 16'($urandom));
    random_traffic(40);
    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("wave_frame_packetizer verification clean");
    end else begin
      $display("wave_frame_packetizer verification failed");
    end
    $finish;
  end

endmodule
